@@ src/cfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpr_pkg
// Shared constants, types and the CRC-16/XMODEM byte update for the framed
// packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpr_pkg;

    // Payload buffer depth and derived widths
    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int FILL_W      = IDX_W + 1;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int MAXLEN_W = 6;
    localparam int CRC_W    = 16;
    localparam int CNT_W    = 16;
    localparam int PIDX_W   = 5;
    localparam int TDATA_W  = 64;

    // Configuration register indexes
    localparam logic CFG_DELIMITER  = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    // Reset values of configuration registers
    localparam logic [BYTE_W-1:0]   DELIM_RST  = 8'h7E;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 6'd32;

    // Frame status codes
    localparam logic STATUS_GOOD    = 1'b0;
    localparam logic STATUS_CORRUPT = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic start;      // delimiter seen: clear CRC and stored high byte
        logic len_ld;     // capture length byte, update CRC
        logic len_drop;   // oversized length: clear CRC
        logic type_ld;    // capture type byte, update CRC, clear fill index
        logic data_ld;    // store payload byte, update CRC, advance fill index
        logic crch_ld;    // capture received CRC high byte
        logic good;       // count a good frame
        logic bad;        // count a corrupt frame
        logic out_single; // load a single result (corrupt or empty payload)
        logic emit_clr;   // restart payload readout
        logic emit_ld;    // load one payload result from the buffer
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic delim_hit;  // input byte equals delimiter
        logic len_bad;    // input length above limit
        logic len_one;    // stored length gives an empty payload
        logic fill_done;  // this payload byte is the last one
        logic crc_ok;     // received CRC matches running CRC
        logic emit_last;  // current readout entry is the last one
        logic out_free;   // output register can take a result this cycle
    } t_sts;

    // CRC-16/XMODEM, one byte per call
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] x;
        x = {crc[7:0], crc[15:8]} ^ {8'h00, b};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

endpackage

`default_nettype wire

@@ src/crc_framed_packet_receiver_top.sv @@
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver_top
// Byte-stream frame receiver with CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_axis channel, one request per byte. The
//   block hunts for the delimiter, then reads length, type, payload and a
//   big-endian CRC. Results leave on the m_axis channel: a good frame gives one
//   result per payload byte (tlast on the final one), or one for an empty
//   payload, a bad frame one with tuser set. Oversized frames drop silently.
//   Configuration (delimiter, max length) is written on the cfg channel at
//   index 0 and 1; cfg_ready is always high. Write only while idle.
// Timing:
//   A corrupt or empty-payload result is registered at the edge that takes
//   the last CRC byte. For a good frame each payload result is read from
//   the buffer in S_RD, set by the registered RAM read, and loaded in S_LD,
//   which waits while the output register is full and not being taken.
//   s_axis_tready is low during the readout, and on the last CRC byte while
//   the output register is full and not being taken.
// Reset:
//   i_rst_n, synchronous active low: hunting state, CRC and counters zero,
//   delimiter 0x7E, max length 32. A stalled receiver holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_receiver_top
    import cfpr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [BYTE_W-1:0]  i_cfg_data,
    // input byte stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] frame_type, [15:8] frame_length, [23:16] payload_byte,
    // [28:24] payload_pos, [44:29] good_count, [60:45] bad_count, rest zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tlast,   // is_last
    output logic                    m_axis_tuser    // [0] frame_status
);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [BYTE_W-1:0] w_type;
    logic [BYTE_W-1:0] w_length;
    logic [BYTE_W-1:0] w_pbyte;
    logic [PIDX_W-1:0] w_pidx;
    logic [CNT_W-1:0]  w_good;
    logic [CNT_W-1:0]  w_bad;

    assign o_cfg_ready = 1'b1;

    cfpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cfpr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_type      (w_type),
        .o_length    (w_length),
        .o_pbyte     (w_pbyte),
        .o_pidx      (w_pidx),
        .o_last      (m_axis_tlast),
        .o_good      (w_good),
        .o_bad       (w_bad)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = {3'b000, w_bad, w_good, w_pidx, w_pbyte, w_length, w_type};

endmodule

`default_nettype wire

@@ src/cfpr_ram.sv @@
// ----------------------------------------------------------------------------
// cfpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/cfpr_dp.sv @@
// ----------------------------------------------------------------------------
// cfpr_dp
// Datapath: configuration registers, frame header capture, running CRC,
// payload buffer, frame counters and the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_dp
    import cfpr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration writes
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [BYTE_W-1:0]   i_cfg_data,
    // input byte
    input  wire logic [BYTE_W-1:0]   i_rx_byte,
    // control
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    // result output
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_status,
    output logic [BYTE_W-1:0]        o_type,
    output logic [BYTE_W-1:0]        o_length,
    output logic [BYTE_W-1:0]        o_pbyte,
    output logic [PIDX_W-1:0]        o_pidx,
    output logic                     o_last,
    output logic [CNT_W-1:0]         o_good,
    output logic [CNT_W-1:0]         o_bad
);

    logic [BYTE_W-1:0]   r_delim;
    logic [MAXLEN_W-1:0] r_maxlen;
    logic [CRC_W-1:0]    r_crc;
    logic [BYTE_W-1:0]   r_crch;
    logic [BYTE_W-1:0]   r_length;
    logic [BYTE_W-1:0]   r_type;
    logic [FILL_W-1:0]   r_fill;
    logic [IDX_W-1:0]    r_emit;
    logic [CNT_W-1:0]    r_good;
    logic [CNT_W-1:0]    r_bad;

    logic [CRC_W-1:0]    n_crc;
    logic [FILL_W-1:0]   n_fill;
    logic [FILL_W-1:0]   w_count;
    logic [CNT_W-1:0]    n_good;
    logic [CNT_W-1:0]    n_bad;
    logic [BYTE_W-1:0]   w_ram_q;

    // Payload byte count: length - 1, or one byte for length zero
    always_comb begin
        if (r_length == '0) begin
            w_count = FILL_W'(1);
        end else begin
            w_count = r_length[FILL_W-1:0] - FILL_W'(1);
        end
    end

    assign n_crc  = crc_update(r_crc, i_rx_byte);
    assign n_fill = r_fill + FILL_W'(1);
    assign n_good = r_good + CNT_W'(1);
    assign n_bad  = r_bad + CNT_W'(1);

    // Status to controller
    assign o_sts.delim_hit = (i_rx_byte == r_delim);
    assign o_sts.len_bad   = (i_rx_byte > {{(BYTE_W-MAXLEN_W){1'b0}}, r_maxlen}) ||
                             (i_rx_byte > BYTE_W'(MAX_PAYLOAD));
    assign o_sts.len_one   = (r_length == BYTE_W'(1));
    assign o_sts.fill_done = (n_fill >= w_count);
    assign o_sts.crc_ok    = ({r_crch, i_rx_byte} == r_crc);
    assign o_sts.emit_last = (({1'b0, r_emit} + FILL_W'(1)) == w_count);
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim  <= DELIM_RST;
            r_maxlen <= MAXLEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELIMITER:  r_delim  <= i_cfg_data;
                CFG_MAX_LENGTH: r_maxlen <= i_cfg_data[MAXLEN_W-1:0];
                default:        r_delim  <= r_delim;
            endcase
        end
    end

    // Header capture, running CRC, buffer indexes and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= '0;
            r_crch   <= '0;
            r_length <= '0;
            r_type   <= '0;
            r_fill   <= '0;
            r_emit   <= '0;
            r_good   <= '0;
            r_bad    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_crc  <= '0;
                r_crch <= '0;
                r_fill <= '0;
            end
            if (i_cmd.len_ld) begin
                r_length <= i_rx_byte;
                r_crc    <= i_cmd.len_drop ? '0 : n_crc;
            end
            if (i_cmd.type_ld) begin
                r_type <= i_rx_byte;
                r_fill <= '0;
                r_crc  <= n_crc;
            end
            if (i_cmd.data_ld) begin
                r_fill <= n_fill;
                r_crc  <= n_crc;
            end
            if (i_cmd.crch_ld) begin
                r_crch <= i_rx_byte;
            end
            if (i_cmd.good) begin
                r_good <= n_good;
            end
            if (i_cmd.bad) begin
                r_bad <= n_bad;
            end
            if (i_cmd.emit_clr) begin
                r_emit <= '0;
            end else if (i_cmd.emit_ld) begin
                r_emit <= r_emit + IDX_W'(1);
            end
        end
    end

    // Payload buffer, read address follows the readout index
    cfpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.data_ld),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_emit),
        .o_rdata (w_ram_q)
    );

    // Output result register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_single || i_cmd.emit_ld) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Output result register: payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_single) begin
            o_status <= i_cmd.bad ? STATUS_CORRUPT : STATUS_GOOD;
            o_type   <= r_type;
            o_length <= r_length;
            o_pbyte  <= '0;
            o_pidx   <= '0;
            o_last   <= 1'b1;
            o_good   <= i_cmd.good ? n_good : r_good;
            o_bad    <= i_cmd.bad ? n_bad : r_bad;
        end else if (i_cmd.emit_ld) begin
            o_status <= STATUS_GOOD;
            o_type   <= r_type;
            o_length <= r_length;
            o_pbyte  <= w_ram_q;
            o_pidx   <= PIDX_W'(r_emit);
            o_last   <= o_sts.emit_last;
            o_good   <= r_good;
            o_bad    <= r_bad;
        end
    end

endmodule

`default_nettype wire

@@ src/cfpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfpr_ctrl
// Frame controller: walks delimiter, length, type, payload and CRC bytes, then
// drives the payload readout into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_ctrl
    import cfpr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_HUNT = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_TYPE = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_CRCH = 3'd4;
    localparam logic [2:0] S_CRCL = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_LD   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_acc;

    // Input is held off during readout and while a final byte has no room
    always_comb begin
        unique case (r_state)
            S_RD, S_LD: o_in_ready = 1'b0;
            S_CRCL:     o_in_ready = i_sts.out_free;
            default:    o_in_ready = 1'b1;
        endcase
    end

    assign w_acc = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (w_acc && i_sts.delim_hit) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LEN;
                end
            end
            S_LEN: begin
                if (w_acc) begin
                    o_cmd.len_ld = 1'b1;
                    if (i_sts.len_bad) begin
                        o_cmd.len_drop = 1'b1;
                        n_state        = S_HUNT;
                    end else begin
                        n_state = S_TYPE;
                    end
                end
            end
            S_TYPE: begin
                if (w_acc) begin
                    o_cmd.type_ld = 1'b1;
                    n_state       = i_sts.len_one ? S_CRCH : S_DATA;
                end
            end
            S_DATA: begin
                if (w_acc) begin
                    o_cmd.data_ld = 1'b1;
                    if (i_sts.fill_done) begin
                        n_state = S_CRCH;
                    end
                end
            end
            S_CRCH: begin
                if (w_acc) begin
                    o_cmd.crch_ld = 1'b1;
                    n_state       = S_CRCL;
                end
            end
            S_CRCL: begin
                if (w_acc) begin
                    if (!i_sts.crc_ok) begin
                        o_cmd.bad        = 1'b1;
                        o_cmd.out_single = 1'b1;
                        n_state          = S_HUNT;
                    end else if (i_sts.len_one) begin
                        o_cmd.good       = 1'b1;
                        o_cmd.out_single = 1'b1;
                        n_state          = S_HUNT;
                    end else begin
                        o_cmd.good     = 1'b1;
                        o_cmd.emit_clr = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            S_RD: begin
                // wait for the registered buffer read
                n_state = S_LD;
            end
            S_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    n_state       = i_sts.emit_last ? S_HUNT : S_RD;
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
